/* rtl/ssdq_pkg.sv */
// ssdq_pkg: shared types and constants of the sphere shell direction quantizer.
// Holds the request/response payload structs and datapath widths.
// No dependencies.
`timescale 1ns / 1ps

package ssdq_pkg;

	// payload widths
	localparam int DIR_W = 16;
	localparam int IDX_W = 12;

	// shared multiplier operand and product widths
	localparam int MUL_W  = 18;
	localparam int PROD_W = 2 * MUL_W;

	// rounded lattice coordinate, signed; covers far-off-unit inputs
	localparam int CRD_W = 14;

	// point count saturates here
	localparam logic [IDX_W-1:0] MAX_COUNT = '1;

	// request kinds
	localparam logic REQ_REBUILD = 1'b0;
	localparam logic REQ_LOOKUP  = 1'b1;

	typedef struct packed {
		logic                    req_type;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
	} req_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] point_index;
		logic             point_valid;
		logic [IDX_W-1:0] point_total;
	} rsp_item_t;

endpackage

/* rtl/ssdq_ram.sv */
// ssdq_ram: generic single-write, single-read RAM with registered read data.
// Parameters set width and depth. No dependencies.
`timescale 1ns / 1ps

module ssdq_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 4851
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     ren,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/ssdq_mul.sv */
// ssdq_mul: the shared signed multiplier with a registered product.
// Used for squares and shell test in rebuild, scaling and addressing in lookup.
// Depends on ssdq_pkg.
`timescale 1ns / 1ps

module ssdq_mul (
	input  logic                                  clk,
	input  logic signed [ssdq_pkg::MUL_W-1:0]     a,
	input  logic signed [ssdq_pkg::MUL_W-1:0]     b,
	output logic signed [ssdq_pkg::PROD_W-1:0]    prod_q
);

	// one product per cycle, registered
	always_ff @(posedge clk) begin
		prod_q <= ssdq_pkg::PROD_W'(a) * ssdq_pkg::PROD_W'(b);
	end

endmodule

/* rtl/sphere_shell_direction_quantizer.sv */
// sphere_shell_direction_quantizer: unit direction to shell point number.
// Lookup: scale, round, range check, address and table read; an off-grid lookup skips the read.
// A lookup with no built table returns invalid without a table read.
// Rebuild: squares, sum, shell test and write per lattice cell (4851 cells half mode, 3375 full).
// All multiplications run through one shared multiplier under the sequencer; one request at a time.
// Reset: half mode selected, table unbuilt, count zero; the table RAM is not cleared.
`timescale 1ns / 1ps

module sphere_shell_direction_quantizer #(
	parameter int HALF_GRID_DIM = 21,
	parameter int FULL_GRID_DIM = 15,
	parameter int DIR_FRAC_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  ssdq_pkg::req_item_t   req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output ssdq_pkg::rsp_item_t   rsp,
	input  logic                  cfg_wen,
	input  logic                  cfg_wdata
);

	localparam int MUL_W  = ssdq_pkg::MUL_W;
	localparam int PROD_W = ssdq_pkg::PROD_W;
	localparam int CRD_W  = ssdq_pkg::CRD_W;
	localparam int IDX_W  = ssdq_pkg::IDX_W;
	localparam int VW     = ssdq_pkg::DIR_W + 1;

	// grid geometry
	localparam int DMAX        = (HALF_GRID_DIM > FULL_GRID_DIM) ? HALF_GRID_DIM : FULL_GRID_DIM;
	localparam int DW          = $clog2(DMAX + 1);
	localparam int CW          = $clog2(DMAX);
	localparam int HALF_KC     = (HALF_GRID_DIM - 1) / 2 + 1;
	localparam int HALF_DEPTH  = HALF_GRID_DIM * HALF_GRID_DIM * HALF_KC;
	localparam int FULL_DEPTH  = FULL_GRID_DIM * FULL_GRID_DIM * FULL_GRID_DIM;
	localparam int TABLE_DEPTH = (HALF_DEPTH > FULL_DEPTH) ? HALF_DEPTH : FULL_DEPTH;
	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int HALF_M      = HALF_GRID_DIM - 2;
	localparam int FULL_M      = FULL_GRID_DIM - 2;

	// rounding shift
	localparam int SH = DIR_FRAC_BITS + 1;
	localparam logic [PROD_W-1:0] LOW_MASK = (PROD_W'(1) << (SH - 1)) - PROD_W'(1);

	typedef enum logic [16:0] {
		S_IDLE = 17'h00001,
		S_RB_X = 17'h00002,
		S_RB_Y = 17'h00004,
		S_RB_Z = 17'h00008,
		S_RB_S = 17'h00010,
		S_RB_T = 17'h00020,
		S_RB_W = 17'h00040,
		S_LK_X = 17'h00080,
		S_LK_Y = 17'h00100,
		S_LK_Z = 17'h00200,
		S_LK_R = 17'h00400,
		S_LK_A = 17'h00800,
		S_LK_B = 17'h01000,
		S_LK_C = 17'h02000,
		S_LK_D = 17'h04000,
		S_LK_E = 17'h08000,
		S_DONE = 17'h10000
	} state_t;

	state_t state_q;

	// control registers
	logic              mode_q;
	logic              ready_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [CW-1:0]     i_q, j_q, k_q;
	logic [AW-1:0]     base_q, addr_q;
	logic              rsp_valid_q;

	// datapath registers
	logic signed [VW-1:0]    vx_q, vy_q, vz_q;
	logic signed [CRD_W-1:0] cx_q, cy_q, cz_q;
	logic signed [MUL_W-1:0] acc_q;
	logic                    oob_q;
	ssdq_pkg::rsp_item_t     res_q;
	ssdq_pkg::rsp_item_t     rsp_q;

	// mode-selected geometry
	logic [DW-1:0]            dim;
	logic [CW-1:0]            dim_last, kc_last;
	logic [AW-1:0]            dd;
	logic signed [MUL_W-1:0]  m_s, dm1_s, c3_s, dim_s;
	logic signed [PROD_W-1:0] thr_s;
	logic signed [CRD_W-1:0]  off_s, zoff_s, dim_c, zmax_c;

	always_comb begin
		if (mode_q) begin
			dim      = DW'(HALF_GRID_DIM);
			dim_last = CW'(HALF_GRID_DIM - 1);
			kc_last  = CW'(HALF_KC - 1);
			dd       = AW'(HALF_GRID_DIM * HALF_GRID_DIM);
			m_s      = MUL_W'(HALF_M);
			dm1_s    = MUL_W'(HALF_GRID_DIM - 1);
			c3_s     = MUL_W'(HALF_M * HALF_M + 3);
			thr_s    = PROD_W'(12 * HALF_M * HALF_M);
			off_s    = CRD_W'((HALF_GRID_DIM - 1) / 2);
			zoff_s   = '0;
			zmax_c   = CRD_W'((HALF_GRID_DIM - 1) / 2);
		end else begin
			dim      = DW'(FULL_GRID_DIM);
			dim_last = CW'(FULL_GRID_DIM - 1);
			kc_last  = CW'(FULL_GRID_DIM - 1);
			dd       = AW'(FULL_GRID_DIM * FULL_GRID_DIM);
			m_s      = MUL_W'(FULL_M);
			dm1_s    = MUL_W'(FULL_GRID_DIM - 1);
			c3_s     = MUL_W'(FULL_M * FULL_M + 3);
			thr_s    = PROD_W'(12 * FULL_M * FULL_M);
			off_s    = CRD_W'((FULL_GRID_DIM - 1) / 2);
			zoff_s   = CRD_W'((FULL_GRID_DIM - 1) / 2);
			zmax_c   = CRD_W'(FULL_GRID_DIM - 1);
		end
		dim_s = signed'(MUL_W'(dim));
		dim_c = signed'(CRD_W'(dim));
	end

	// round half to even of p / 2^SH
	function automatic logic signed [CRD_W-1:0] round_he(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0]       a;
		logic [PROD_W-1:0]       q;
		logic                    up;
		logic signed [CRD_W-1:0] r;
		a  = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		q  = a >> SH;
		up = a[SH-1] && (((a & LOW_MASK) != '0) || q[0]);
		q  = q + PROD_W'(up);
		r  = signed'(q[CRD_W-1:0]);
		return p[PROD_W-1] ? -r : r;
	endfunction

	// shared multiplier
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [MUL_W-1:0]  prod_lo;
	logic signed [MUL_W-1:0]  x_lat, y_lat, z_lat;

	assign prod_lo = signed'(prod_q[MUL_W-1:0]);
	assign x_lat   = signed'(MUL_W'({i_q, 1'b0})) - dm1_s;
	assign y_lat   = signed'(MUL_W'({j_q, 1'b0})) - dm1_s;
	assign z_lat   = mode_q ? signed'(MUL_W'({k_q, 1'b0}))
	                        : signed'(MUL_W'({k_q, 1'b0})) - dm1_s;

	// operand select per sequencer step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_RB_X: begin mul_a = x_lat; mul_b = x_lat; end
			S_RB_Y: begin mul_a = y_lat; mul_b = y_lat; end
			S_RB_Z: begin mul_a = z_lat; mul_b = z_lat; end
			S_RB_T: begin mul_a = acc_q; mul_b = acc_q; end
			S_LK_X: begin mul_a = MUL_W'(vx_q); mul_b = m_s; end
			S_LK_Y: begin mul_a = MUL_W'(vy_q); mul_b = m_s; end
			S_LK_Z: begin mul_a = MUL_W'(vz_q); mul_b = m_s; end
			S_LK_A: begin mul_a = MUL_W'(cz_q); mul_b = dim_s; end
			S_LK_C: begin mul_a = acc_q; mul_b = dim_s; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	ssdq_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// shell test and count for the current cell
	logic             hit;
	logic [IDX_W-1:0] cnt_nx;

	assign hit    = prod_q < thr_s;
	assign cnt_nx = (hit && (cnt_q != ssdq_pkg::MAX_COUNT)) ? cnt_q + IDX_W'(1) : cnt_q;

	// table RAM: {occupied, point number}
	logic                  ram_wen, ram_ren;
	logic [IDX_W:0]        ram_wdata, ram_rdata;
	logic [AW-1:0]         ram_raddr;
	logic signed [MUL_W-1:0] rd_sum;

	assign ram_wen   = (state_q == S_RB_W);
	assign ram_wdata = {hit, cnt_q};
	assign rd_sum    = prod_lo + MUL_W'(cx_q);
	assign ram_raddr = rd_sum[AW-1:0];
	assign ram_ren   = (state_q == S_LK_D);

	ssdq_ram #(
		.WIDTH (IDX_W + 1),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.wen   (ram_wen),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.ren   (ram_ren),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// lookup range check on rounded coordinates
	logic off_grid;
	assign off_grid = (cx_q < 0) || (cx_q >= dim_c) || (cy_q < 0) || (cy_q >= dim_c)
	               || (cz_q < 0) || (cz_q > zmax_c);

	logic req_xfer, rsp_xfer, rsp_load;
	assign req_xfer = req_valid && !req_stall;
	assign rsp_xfer = rsp_valid_q && !rsp_stall;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= 1'b1;
			ready_q     <= 1'b0;
			cnt_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			base_q      <= '0;
			addr_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// config write; a mode change drops the table
			if (cfg_wen) begin
				mode_q <= cfg_wdata;
				if (cfg_wdata != mode_q) begin
					ready_q <= 1'b0;
				end
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_xfer) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						if (req.req_type == ssdq_pkg::REQ_REBUILD) begin
							cnt_q   <= '0;
							i_q     <= '0;
							j_q     <= '0;
							k_q     <= '0;
							base_q  <= '0;
							addr_q  <= '0;
							state_q <= S_RB_X;
						end else if (ready_q) begin
							state_q <= S_LK_X;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_RB_X: state_q <= S_RB_Y;
				S_RB_Y: state_q <= S_RB_Z;
				S_RB_Z: state_q <= S_RB_S;
				S_RB_S: state_q <= S_RB_T;
				S_RB_T: state_q <= S_RB_W;
				S_RB_W: begin
					// write cell, then step z inner, y, x outer
					cnt_q <= cnt_nx;
					if (k_q == kc_last) begin
						k_q <= '0;
						if (j_q == dim_last) begin
							j_q <= '0;
							if (i_q == dim_last) begin
								ready_q <= 1'b1;
								state_q <= S_DONE;
							end else begin
								i_q     <= i_q + CW'(1);
								base_q  <= AW'(i_q) + AW'(1);
								addr_q  <= AW'(i_q) + AW'(1);
								state_q <= S_RB_X;
							end
						end else begin
							j_q     <= j_q + CW'(1);
							base_q  <= base_q + AW'(dim);
							addr_q  <= base_q + AW'(dim);
							state_q <= S_RB_X;
						end
					end else begin
						k_q     <= k_q + CW'(1);
						addr_q  <= addr_q + dd;
						state_q <= S_RB_X;
					end
				end
				S_LK_X: state_q <= S_LK_Y;
				S_LK_Y: state_q <= S_LK_Z;
				S_LK_Z: state_q <= S_LK_R;
				S_LK_R: state_q <= S_LK_A;
				S_LK_A: state_q <= S_LK_B;
				S_LK_B: state_q <= S_LK_C;
				S_LK_C: state_q <= S_LK_D;
				S_LK_D: state_q <= oob_q ? S_DONE : S_LK_E;
				S_LK_E: state_q <= S_DONE;
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// lookup vector, possibly mirrored into the upper half
	logic signed [VW-1:0] in_x, in_y, in_z;
	logic                 mirror;

	assign in_x   = VW'(req.dir_x);
	assign in_y   = VW'(req.dir_y);
	assign in_z   = VW'(req.dir_z);
	assign mirror = mode_q && req.dir_z[ssdq_pkg::DIR_W-1];

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				vx_q  <= mirror ? -in_x : in_x;
				vy_q  <= mirror ? -in_y : in_y;
				vz_q  <= mirror ? -in_z : in_z;
				res_q <= '0;
			end
			S_RB_Y: acc_q <= prod_lo;
			S_RB_Z: acc_q <= acc_q + prod_lo;
			S_RB_S: acc_q <= acc_q + prod_lo - c3_s;
			S_RB_W: begin
				res_q <= '{point_index: '0, point_valid: 1'b0, point_total: cnt_nx};
			end
			S_LK_Y: cx_q <= round_he(prod_q) + off_s;
			S_LK_Z: cy_q <= round_he(prod_q) + off_s;
			S_LK_R: cz_q <= round_he(prod_q) + zoff_s;
			S_LK_A: oob_q <= off_grid;
			S_LK_B: acc_q <= prod_lo + MUL_W'(cy_q);
			S_LK_E: begin
				res_q <= '{point_index: ram_rdata[IDX_W] ? ram_rdata[IDX_W-1:0] : '0,
				           point_valid: ram_rdata[IDX_W],
				           point_total: '0};
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
